>>> design/idc_pkg.sv
package idc_pkg;

    // Sample and window geometry
    localparam int SAMPLE_BITS   = 28;
    localparam int WINDOW_DEPTH  = 4;
    localparam int WIN_IDX_BITS  = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS      = SAMPLE_BITS + WIN_IDX_BITS;

    // Register widths
    localparam int LEVEL_BITS    = 28;
    localparam int THR_BITS      = 16;
    localparam int CFG_DATA_BITS = 28;
    localparam int CFG_IDX_BITS  = 2;

    // Percentage math
    localparam int PCT_BITS      = 7;
    localparam int OFS_BITS      = LEVEL_BITS + 1;        // signed level difference
    localparam int PROD_BITS     = LEVEL_BITS + PCT_BITS; // |offset| * 100
    localparam int DIV_BITS      = 36;                    // quotient bits, one per cycle
    localparam int DEN_BITS      = LEVEL_BITS + 2;        // |span| * 2
    localparam int STEP_BITS     = $clog2(DIV_BITS);

    localparam logic [PCT_BITS-1:0] PCT_FULL  = PCT_BITS'(100);
    localparam logic [PCT_BITS-1:0] PCT_HALF  = PCT_BITS'(50);
    localparam logic [PCT_BITS-1:0] PASS_LOW  = PCT_BITS'(45);
    localparam logic [PCT_BITS-1:0] PASS_HIGH = PCT_BITS'(55);
    localparam logic [PCT_BITS-1:0] PCT_ZERO  = '0;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_FAR  = 2'd1;
    localparam logic [1:0] VERDICT_NEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAL_DONE    = 2'd3;

    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(50);

endpackage

>>> design/inductive_distance_classifier_unit.sv
// Inductive distance classifier.
// Input channel (s_valid/s_ready, s_sample): one raw sensor conversion per
// transaction. It enters a four-entry ring; the truncated ring average
// replaces the held level when it moves by more than the deadband threshold.
// Result channel (m_valid/m_ready): one transaction per input with the held
// level, the calibrated distance percentage (100 empty, 50 reference), the
// pass/far/near verdict and a copy of calibration_done.
// Configuration: cfg_wr_en with cfg_index and cfg_wdata, written while idle.
// Sequence: after acceptance an item goes through the ring sum, the
// deadband step, the multiply, the bit-serial divider and a finish step
// when calibrated; when not calibrated or when both calibration levels are
// equal it skips the divider. s_ready stays low until the sequencer returns
// to idle after the finish step. The divider takes one quotient bit a cycle.
// The result sits in an output register; the next transaction is accepted
// while it waits. If the receiver stalls, the finished item waits at the
// finish step until the output register frees.
// Reset clears the ring, the held level and the configuration registers (threshold 50).
module inductive_distance_classifier_unit
    import idc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_sample,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [LEVEL_BITS-1:0]    m_held_level,
    output logic [PCT_BITS-1:0]      m_distance_percent,
    output logic [1:0]               m_verdict,
    output logic                     m_distance_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_HOLD,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    // Configuration registers
    logic [LEVEL_BITS-1:0] empty_level_reg;
    logic [LEVEL_BITS-1:0] ref_level_reg;
    logic [THR_BITS-1:0]   threshold_reg;
    logic                  cal_done_reg;

    // Datapath state
    state_t                 state_reg;
    logic [SAMPLE_BITS-1:0] window_reg [WINDOW_DEPTH];
    logic [WIN_IDX_BITS-1:0] slot_reg;
    logic [SAMPLE_BITS-1:0] hold_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [DIV_BITS-1:0]    quo_reg;
    logic [DEN_BITS-1:0]    den_reg;
    logic [DEN_BITS-1:0]    rem_reg;
    logic [PCT_BITS-1:0]    pct_reg;

    // Output register
    logic                   m_valid_reg;
    logic [LEVEL_BITS-1:0]  m_held_reg;
    logic [PCT_BITS-1:0]    m_pct_reg;
    logic [1:0]             m_verdict_reg;
    logic                   m_dvalid_reg;

    // Combinational helpers
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] diff;
    logic signed [OFS_BITS-1:0] offset;
    logic signed [OFS_BITS-1:0] span;
    logic [LEVEL_BITS-1:0]  offset_mag;
    logic [LEVEL_BITS-1:0]  span_mag;
    logic [PROD_BITS-1:0]   prod;
    logic [DEN_BITS:0]      rem_shift;
    logic                   fits;
    logic [DEN_BITS-1:0]    rem_next;
    logic [DIV_BITS-1:0]    quo_next;
    logic                   neg_reg;
    logic [PCT_BITS-1:0]    pct_div;
    logic [1:0]             verdict_next;
    logic                   out_free;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_level_reg <= '0;
            ref_level_reg   <= '0;
            threshold_reg   <= THRESHOLD_RESET;
            cal_done_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EMPTY_LEVEL: empty_level_reg <= cfg_wdata[LEVEL_BITS-1:0];
                REG_REF_LEVEL:   ref_level_reg   <= cfg_wdata[LEVEL_BITS-1:0];
                REG_THRESHOLD:   threshold_reg   <= cfg_wdata[THR_BITS-1:0];
                REG_CAL_DONE:    cal_done_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Deadband on the ring average
    assign avg  = sum_reg[SUM_BITS-1:WIN_IDX_BITS];
    assign diff = (avg >= hold_reg) ? (avg - hold_reg) : (hold_reg - avg);

    // Signed offset and span, magnitudes, scale by 100
    assign offset     = $signed({1'b0, hold_reg}) - $signed({1'b0, empty_level_reg});
    assign span       = $signed({1'b0, ref_level_reg}) - $signed({1'b0, empty_level_reg});
    assign offset_mag = offset[OFS_BITS-1] ? LEVEL_BITS'(-offset) : offset[LEVEL_BITS-1:0];
    assign span_mag   = span[OFS_BITS-1] ? LEVEL_BITS'(-span) : span[LEVEL_BITS-1:0];
    assign prod       = PROD_BITS'(offset_mag) * PROD_BITS'(PCT_FULL);

    // One restoring divider step
    assign rem_shift = {rem_reg, quo_reg[DIV_BITS-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_next  = fits ? DEN_BITS'(rem_shift - {1'b0, den_reg})
                            : rem_shift[DEN_BITS-1:0];
    assign quo_next  = {quo_reg[DIV_BITS-2:0], fits};

    // Percentage from the final quotient, clamped to 0..100
    always_comb begin
        if (neg_reg) begin
            pct_div = PCT_FULL;
        end else if (quo_next >= DIV_BITS'(PCT_FULL)) begin
            pct_div = PCT_ZERO;
        end else begin
            pct_div = PCT_FULL - quo_next[PCT_BITS-1:0];
        end
    end

    // Verdict
    always_comb begin
        if (!cal_done_reg) begin
            verdict_next = VERDICT_PASS;
        end else if (pct_reg > PASS_HIGH) begin
            verdict_next = VERDICT_FAR;
        end else if (pct_reg < PASS_LOW) begin
            verdict_next = VERDICT_NEAR;
        end else begin
            verdict_next = VERDICT_PASS;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            hold_reg    <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            // load on finish, else drop once the result is taken
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        window_reg[slot_reg] <= s_sample;
                        slot_reg  <= slot_reg + 1'b1;
                        sum_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    sum_reg  <= sum_reg + SUM_BITS'(window_reg[step_reg[WIN_IDX_BITS-1:0]]);
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_BITS'(WINDOW_DEPTH - 1)) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (diff > SAMPLE_BITS'(threshold_reg)) begin
                        hold_reg <= avg;
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (!cal_done_reg) begin
                        pct_reg   <= PCT_ZERO;
                        state_reg <= ST_FIN;
                    end else if (span == '0) begin
                        pct_reg   <= PCT_HALF;
                        state_reg <= ST_FIN;
                    end else begin
                        quo_reg   <= DIV_BITS'(prod);
                        den_reg   <= {1'b0, span_mag, 1'b0};
                        rem_reg   <= '0;
                        neg_reg   <= offset[OFS_BITS-1] ^ span[OFS_BITS-1];
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_BITS'(DIV_BITS - 1)) begin
                        pct_reg   <= pct_div;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_held_reg    <= hold_reg;
                        m_pct_reg     <= pct_reg;
                        m_verdict_reg <= verdict_next;
                        m_dvalid_reg  <= cal_done_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_held_level       = m_held_reg;
    assign m_distance_percent = m_pct_reg;
    assign m_verdict          = m_verdict_reg;
    assign m_distance_valid   = m_dvalid_reg;

endmodule
